// ----- rtl/sha256md_pkg.sv -----
`timescale 1ns / 1ps

package sha256md_pkg;

    // One input beat: up to four message bytes, first byte in the top lane.
    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last;
    } t_in_beat;

    // One output beat: a single word of the finished digest.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        final_word;
    } t_out_beat;

    // Sources that the byte packer can take bytes from.
    localparam logic [2:0] SRC_INPUT  = 3'd0;
    localparam logic [2:0] SRC_PAD    = 3'd1;
    localparam logic [2:0] SRC_ZERO   = 3'd2;
    localparam logic [2:0] SRC_LEN_HI = 3'd3;
    localparam logic [2:0] SRC_LEN_LO = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       absorb;
        logic [2:0] src;
        logic       load_vars;
        logic       round;
        logic       update;
        logic       emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic acc_empty;
        logic len_slot;
        logic round_last;
        logic out_busy;
    } t_dp_status;

    localparam logic [31:0] H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- rtl/sha256md_dp.sv -----
`timescale 1ns / 1ps

module sha256md_dp
    import sha256md_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_beat   i_in_data,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_beat  o_out_data
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Chaining value, working variables a..h and the 16-word schedule window.
    logic [31:0] r_h [0:7];
    logic [31:0] r_v [0:7];
    logic [31:0] r_w [0:15];
    logic [63:0] r_len;
    logic [31:0] r_acc;
    logic [1:0]  r_acc_n;
    logic [4:0]  r_words;
    logic [5:0]  r_round;
    logic [31:0] r_out_words [0:7];
    logic [2:0]  r_out_idx;
    logic        r_out_valid;

    // Byte packer: pick the source and its byte count.
    logic [31:0] src_word;
    logic [2:0]  src_cnt;
    logic [31:0] keep_mask;
    logic [63:0] combined;
    logic [2:0]  total;
    logic        push;
    logic [31:0] n_acc;
    logic [1:0]  n_acc_n;

    always_comb begin
        unique case (i_cmd.src)
            SRC_INPUT: begin
                src_word = i_in_data.message_word;
                src_cnt  = (i_in_data.byte_count > 3'd4) ? 3'd4 : i_in_data.byte_count;
            end
            SRC_PAD: begin
                src_word = 32'h8000_0000;
                src_cnt  = 3'd1;
            end
            SRC_ZERO: begin
                src_word = 32'h0;
                src_cnt  = 3'd4 - {1'b0, r_acc_n};
            end
            SRC_LEN_HI: begin
                src_word = r_len[63:32];
                src_cnt  = 3'd4;
            end
            SRC_LEN_LO: begin
                src_word = r_len[31:0];
                src_cnt  = 3'd4;
            end
            default: begin
                src_word = 32'h0;
                src_cnt  = 3'd0;
            end
        endcase
    end

    // Append the valid bytes behind the bytes already held.
    always_comb begin
        keep_mask = ~(32'hffff_ffff >> {src_cnt, 3'b000});
        combined  = {r_acc, 32'h0} | ({src_word & keep_mask, 32'h0} >> {r_acc_n, 3'b000});
        total     = {1'b0, r_acc_n} + src_cnt;
        push      = i_cmd.absorb && total[2];
        n_acc     = total[2] ? combined[31:0] : combined[63:32];
        n_acc_n   = total[1:0];
    end

    // Message schedule and round function.
    logic [31:0] sig0, sig1, w_next;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    always_comb begin
        sig0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        sig1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_next = r_w[0] + sig0 + r_w[9] + sig1;
        big1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big1 + ch + ROUND_K[r_round] + r_w[0];
        big0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big0 + maj;
    end

    // Control state: chaining value, length, packer fill, counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= H_INIT[i];
            end
            r_len     <= 64'h0;
            r_acc     <= 32'h0;
            r_acc_n   <= 2'd0;
            r_words   <= 5'd0;
            r_round   <= 6'd0;
        end else begin
            if (i_cmd.absorb) begin
                r_acc   <= n_acc;
                r_acc_n <= n_acc_n;
                if (i_cmd.src == SRC_INPUT) begin
                    r_len <= r_len + {58'h0, src_cnt, 3'b000};
                end
            end
            if (push) begin
                r_words <= r_words + 5'd1;
            end
            if (i_cmd.load_vars) begin
                r_round <= 6'd0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
                r_words <= 5'd0;
            end
            if (i_cmd.emit) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= H_INIT[i];
                end
                r_len <= 64'h0;
            end
        end
    end

    // Schedule window: packed words shift in at the top, rounds extend it.
    always_ff @(posedge i_clk) begin
        if (push || i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= push ? combined[63:32] : w_next;
        end
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // Output buffer: holds a finished digest and drains one beat per handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= 3'd0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= 3'd0;
        end else if (r_out_valid && i_out_ready) begin
            r_out_idx <= r_out_idx + 3'd1;
            if (&r_out_idx) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int i = 0; i < 8; i++) begin
                r_out_words[i] <= r_h[i];
            end
        end else if (r_out_valid && i_out_ready) begin
            for (int i = 0; i < 7; i++) begin
                r_out_words[i] <= r_out_words[i + 1];
            end
            r_out_words[7] <= 32'h0;
        end
    end

    assign o_status.full       = r_words[4];
    assign o_status.acc_empty  = (r_acc_n == 2'd0);
    assign o_status.len_slot   = (r_words == 5'd14);
    assign o_status.round_last = (&r_round);
    assign o_status.out_busy   = r_out_valid;

    assign o_out_valid            = r_out_valid;
    assign o_out_data.digest_word = r_out_words[0];
    assign o_out_data.word_index  = r_out_idx;
    assign o_out_data.final_word  = &r_out_idx;

`ifndef ASSERT_OFF
    // Bytes are never packed into a block that is waiting for compression.
    a_no_absorb_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.absorb |-> !r_words[4])
        else $error("absorb while block buffer is full");

    // Rounds only run on a complete block.
    a_round_on_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> (r_words == 5'd16))
        else $error("round issued on an incomplete block");

    // A digest is emitted only when padding left nothing and output is free.
    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_acc_n == 2'd0) && (r_words == 5'd0) && !r_out_valid)
        else $error("emit with bytes pending or output busy");
`endif

endmodule

// ----- rtl/sha256md_ctrl.sv -----
`timescale 1ns / 1ps

module sha256md_ctrl
    import sha256md_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_ZERO   = 4'd2;
    localparam logic [3:0] S_LEN_HI = 4'd3;
    localparam logic [3:0] S_LEN_LO = 4'd4;
    localparam logic [3:0] S_START  = 4'd5;
    localparam logic [3:0] S_ROUND  = 4'd6;
    localparam logic [3:0] S_UPDATE = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;

    assign o_in_ready = (r_state == S_IDLE) && !i_status.full;

    // Next state and datapath commands.
    always_comb begin
        n_state         = r_state;
        n_ret           = r_ret;
        o_cmd           = '0;
        o_cmd.src       = SRC_INPUT;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.full) begin
                    o_cmd.load_vars = 1'b1;
                    n_ret           = S_IDLE;
                    n_state         = S_ROUND;
                end else if (i_in_valid) begin
                    o_cmd.absorb = 1'b1;
                    if (i_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (i_status.full) begin
                    o_cmd.load_vars = 1'b1;
                    n_ret           = S_PAD;
                    n_state         = S_ROUND;
                end else begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.src    = SRC_PAD;
                    n_state      = S_ZERO;
                end
            end
            S_ZERO: begin
                if (i_status.full) begin
                    o_cmd.load_vars = 1'b1;
                    n_ret           = S_ZERO;
                    n_state         = S_ROUND;
                end else if (i_status.acc_empty && i_status.len_slot) begin
                    n_state = S_LEN_HI;
                end else begin
                    o_cmd.absorb = 1'b1;
                    o_cmd.src    = SRC_ZERO;
                end
            end
            S_LEN_HI: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = SRC_LEN_HI;
                n_state      = S_LEN_LO;
            end
            S_LEN_LO: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = SRC_LEN_LO;
                n_state      = S_START;
            end
            S_START: begin
                o_cmd.load_vars = 1'b1;
                n_ret           = S_EMIT;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = r_ret;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

// ----- rtl/sha256_message_digest.sv -----
`timescale 1ns / 1ps

// SHA-256 digest of a byte stream given as big-endian 32-bit words; a beat
// carries 0 to 4 left-aligned bytes, and the beat marked last closes the
// message (it may carry no bytes; a lone such beat gives the digest of the
// empty string). An input beat is taken only while the controller is idle
// and the block buffer is not full. Each 16-word block then runs through a
// single round unit, which loads the working registers, runs 64 rounds and
// folds the result into the chaining value; no input is taken meanwhile.
// Closing a message adds the padding and the final block, plus one more
// block when the length no longer fits, after which the eight digest words
// leave from an output buffer at one beat per cycle while i_out_ready is
// high, index 0 first, final_word set on the eighth. The buffer drains while
// the next message is already being taken.
module sha256_message_digest
    import sha256md_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing of packing, padding, compression and emission.
    sha256md_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_data.last),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Byte packer, schedule, round unit, chaining value and output buffer.
    sha256md_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
